// ----- src/packet_deframer_crc16_check_top_macros.svh -----
// Assertion macros for the packet deframer with CRC-16 check.
// Used by the port-level checker; needs clk and rst_n in scope.
`ifndef PACKET_DEFRAMER_CRC16_CHECK_TOP_MACROS_SVH
`define PACKET_DEFRAMER_CRC16_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pdc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the packet deframer.
// No dependencies; imported by the top level and the checker.
package pdc_pkg;

  localparam int unsigned CNT_W      = 11;
  localparam int unsigned OBUF_DEPTH = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX    = 11'h7FF;
  localparam logic [CNT_W-1:0] HDR_BYTES    = 11'd4;
  localparam logic [CNT_W-1:0] TRL_BYTES    = 11'd2;
  localparam logic [CNT_W-1:0] HDR_TRL_MIN  = 11'd6;
  localparam logic [15:0]      CRC_GEN      = 16'h1021;
  localparam logic [15:0]      CRC_INIT     = 16'h0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_CRC_ERR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic             is_status;
    logic [7:0]       payload_byte;
    status_t          status;
    logic [31:0]      hdr_word;
    logic [CNT_W-1:0] payload_count;
  } result_t;

  // CRC-16, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_GEN) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- src/packet_deframer_crc16_check_top.sv -----
// Packet deframer with CRC-16 check: top level.
// Depends on pdc_pkg (types, constants, CRC byte update).
//
// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+------------------------------------------
// in_      | input     | in_valid/in_stall | rx_byte, final_byte
// out_     | output    | out_valid/out_stall | is_status, payload_byte, status_code,
//          |           |                   | header fields, payload_count
// cfg_     | input     | cfg_wr_en         | cfg_wr_data (max_payload_len)
//
// One byte is accepted per cycle when not stalled. Each byte is decoded in
// the cycle it is accepted and its results (zero, one or two) land in an
// OutDepth-entry result queue that drains one transaction per cycle when
// out_stall is low; its head drives out_. A final byte that is also a payload
// byte yields two results, so the input stalls whenever fewer than two queue
// entries are free. Reset is synchronous, active low: it empties the queue,
// clears the packet state and sets max_payload_len to 2047.
module packet_deframer_crc16_check_top
  import pdc_pkg::*;
#(
  parameter int unsigned OutDepth = OBUF_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_final_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_status,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_status_code,
  output logic [2:0]       out_packet_version,
  output logic [6:0]       out_application_id,
  output logic [3:0]       out_service_kind,
  output logic [4:0]       out_message_kind,
  output logic [CNT_W-1:0] out_total_length,
  output logic             out_ack_bit,
  output logic             out_check_present,
  output logic [CNT_W-1:0] out_payload_count
);

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  // packet state
  logic [CNT_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [31:0]      hdr_r, hdr_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      trl_r, trl_nxt;
  logic [CNT_W-1:0] max_len_r;

  // result queue
  result_t          queue_r [OutDepth];
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  logic in_fire, out_fire;

  // decode of the current byte
  logic             pos_hdr;
  logic [CNT_W-1:0] len_c, end_c;
  logic             chk_c, body_ok, crc_on, trl_on, emit_pay;
  logic [CNT_W-1:0] idx_inc;
  logic [31:0]      hdr_step;
  logic [15:0]      crc_step, trl_step;

  // end-of-packet status
  logic             have_hdr, bad_len;
  logic [31:0]      w_f;
  logic [CNT_W-1:0] len_f, pcount_f;
  logic             chk_f;
  status_t          status_f;
  result_t          pay_res, stat_res;
  logic [PtrW-1:0]  wr_ptr_p1;
  logic [CntW-1:0]  push_n;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(OutDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Keep room for a payload byte plus its status before taking a byte.
  assign in_stall  = (count_r > CntW'(OutDepth - 2));
  assign out_valid = (count_r != '0);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  // Header bytes always feed the header word and the CRC.
  assign pos_hdr = (byte_idx_r < HDR_BYTES);
  assign len_c   = hdr_r[12:2];
  assign chk_c   = hdr_r[0];
  assign body_ok = chk_c ? (len_c >= HDR_TRL_MIN) : (len_c >= HDR_BYTES);
  assign end_c   = chk_c ? (body_ok ? len_c - TRL_BYTES : '0) : len_c;

  // The CRC covers everything before the trailer, trailer bytes are captured
  // separately, and bytes past the length are ignored.
  assign crc_on   = (len_c >= TRL_BYTES) && (byte_idx_r < len_c - TRL_BYTES);
  assign trl_on   = chk_c && body_ok && (byte_idx_r >= end_c) && (byte_idx_r < len_c);
  assign emit_pay = !pos_hdr && body_ok && (byte_idx_r < end_c);

  assign idx_inc  = (byte_idx_r == COUNT_MAX) ? byte_idx_r : byte_idx_r + 1'b1;
  assign hdr_step = pos_hdr ? {hdr_r[23:0], in_rx_byte} : hdr_r;
  assign crc_step = (pos_hdr || crc_on) ? crc16_byte(crc_r, in_rx_byte) : crc_r;
  assign trl_step = (!pos_hdr && trl_on) ? {trl_r[7:0], in_rx_byte} : trl_r;

  // Status on the final byte, from the state as updated by that byte.
  assign have_hdr = (idx_inc >= HDR_BYTES);
  assign w_f      = have_hdr ? hdr_step : '0;
  assign len_f    = w_f[12:2];
  assign chk_f    = w_f[0];
  assign bad_len  = !have_hdr || (len_f > idx_inc) || (len_f < HDR_BYTES) ||
                    (chk_f && (len_f < HDR_TRL_MIN));
  assign pcount_f = len_f - HDR_BYTES - (chk_f ? TRL_BYTES : '0);

  always_comb begin
    if (bad_len) begin
      status_f = ST_INVALID;
    end else if (chk_f && (trl_step != crc_step)) begin
      status_f = ST_CRC_ERR;
    end else if (pcount_f > max_len_r) begin
      status_f = ST_OVERFLOW;
    end else begin
      status_f = ST_OK;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.is_status    = 1'b0;
    pay_res.payload_byte = in_rx_byte;

    stat_res               = '0;
    stat_res.is_status     = 1'b1;
    stat_res.status        = status_f;
    stat_res.hdr_word      = w_f;
    stat_res.payload_count = bad_len ? '0 : pcount_f;
  end

  // Advance or clear the packet state on each accepted byte.
  always_comb begin
    byte_idx_nxt = byte_idx_r;
    hdr_nxt      = hdr_r;
    crc_nxt      = crc_r;
    trl_nxt      = trl_r;
    if (in_fire) begin
      if (in_final_byte) begin
        byte_idx_nxt = '0;
        hdr_nxt      = '0;
        crc_nxt      = CRC_INIT;
        trl_nxt      = '0;
      end else begin
        byte_idx_nxt = idx_inc;
        hdr_nxt      = hdr_step;
        crc_nxt      = crc_step;
        trl_nxt      = trl_step;
      end
    end
  end

  // Queue bookkeeping: payload byte goes in first, then the status.
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign push_n    = in_fire ? (CntW'(emit_pay) + CntW'(in_final_byte)) : '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == CntW'(2)) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end else if (push_n == CntW'(1)) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = out_fire ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + push_n - CntW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
      hdr_r      <= '0;
      crc_r      <= CRC_INIT;
      trl_r      <= '0;
      max_len_r  <= COUNT_MAX;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      byte_idx_r <= byte_idx_nxt;
      hdr_r      <= hdr_nxt;
      crc_r      <= crc_nxt;
      trl_r      <= trl_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      count_r    <= count_nxt;
    end
  end

  // Queue storage holds only result data (payload and status entries); no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (emit_pay) begin
        queue_r[wr_ptr_r] <= pay_res;
        if (in_final_byte) begin
          queue_r[wr_ptr_p1] <= stat_res;
        end
      end else if (in_final_byte) begin
        queue_r[wr_ptr_r] <= stat_res;
      end
    end
  end

  // Head of the queue drives the result ports.
  result_t head;
  assign head = queue_r[rd_ptr_r];

  assign out_is_status      = head.is_status;
  assign out_payload_byte   = head.payload_byte;
  assign out_status_code    = head.status;
  assign out_packet_version = head.hdr_word[31:29];
  assign out_application_id = head.hdr_word[28:22];
  assign out_service_kind   = head.hdr_word[21:18];
  assign out_message_kind   = head.hdr_word[17:13];
  assign out_total_length   = head.hdr_word[12:2];
  assign out_ack_bit        = head.hdr_word[1];
  assign out_check_present  = head.hdr_word[0];
  assign out_payload_count  = head.payload_count;

endmodule

// ----- src/pdc_checker.sv -----
// Port-level checker for the packet deframer, bound to the top level.
// Depends on pdc_pkg and packet_deframer_crc16_check_top_macros.svh.
`include "packet_deframer_crc16_check_top_macros.svh"

module pdc_checker
  import pdc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_is_status,
  input logic [1:0]       out_status_code,
  input logic [2:0]       out_packet_version,
  input logic             out_check_present,
  input logic [CNT_W-1:0] out_total_length,
  input logic [CNT_W-1:0] out_payload_count
);

  `PDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `PDC_ASSERT_NOW(a_pay_clean, out_valid && !out_is_status, (out_status_code == ST_OK) && (out_payload_count == '0) && (out_total_length == '0) && (out_packet_version == '0) && !out_check_present, "payload transaction carries status fields")

  `PDC_ASSERT_NOW(a_invalid_count, out_valid && out_is_status && (out_status_code == ST_INVALID), out_payload_count == '0, "invalid status with nonzero payload count")

  `PDC_ASSERT_NOW(a_ok_count, out_valid && out_is_status && (out_status_code == ST_OK), ({1'b0, out_payload_count} + 12'd4) <= {1'b0, out_total_length}, "payload count exceeds length less header")

endmodule

bind packet_deframer_crc16_check_top pdc_checker u_pdc_checker (.*);
